// ----- hw/rtl/icalc_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Integer calculator ALU package
// Widths, command and status codes, serial unit opcodes and the request and
// response structs between the top level and the serial unit.
// ---------------------------------------------------------------------------
package icalc_pkg;

   // Operand width; each operand is the low WIDTH bits of its field
   localparam int WIDTH       = 32;
   localparam int CMD_W       = 3;
   localparam int FIELD_W     = 32;
   localparam int RES_W       = 64;
   localparam int STS_W       = 2;
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 72;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RES_W - STS_W;

   // Serial unit step counter and square root step count
   localparam int CNT_W    = $clog2(WIDTH + 1);
   localparam int SQ_STEPS = WIDTH / 2;

   // Commands
   localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SUB    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_MUL    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DIV    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_MOD    = 3'd4;
   localparam logic [CMD_W-1:0] CMD_SQUARE = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SQRT   = 3'd6;
   localparam logic [CMD_W-1:0] CMD_LOG2   = 3'd7;

   // Status codes
   localparam logic [STS_W-1:0] STS_OK       = 2'd0;
   localparam logic [STS_W-1:0] STS_DIV_ZERO = 2'd1;
   localparam logic [STS_W-1:0] STS_INVALID  = 2'd2;

   // Serial unit operations
   localparam logic [1:0] ENG_MUL  = 2'd0;
   localparam logic [1:0] ENG_DIV  = 2'd1;
   localparam logic [1:0] ENG_SQRT = 2'd2;
   localparam logic [1:0] ENG_LOG  = 2'd3;

   typedef struct packed {
      logic             start;
      logic [1:0]       op;
      logic [WIDTH-1:0] a;
      logic [WIDTH-1:0] b;
   } eng_req_type;

   typedef struct packed {
      logic             done;
      logic [WIDTH-1:0] hi;
      logic [WIDTH-1:0] lo;
   } eng_rsp_type;

endpackage

// ----- hw/rtl/integer_calculator_alu_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Integer calculator ALU
// Add, subtract, multiply, divide, remainder, square, square root and
// ceiling base-2 log on signed operands, with a status per result.
// ---------------------------------------------------------------------------
// One request is worked at a time. Add, subtract, error cases and the log of
// one or less finish without the serial unit. Multiply, square, divide and
// remainder run a one-bit-per-cycle shift-add or restoring subtract loop of
// WIDTH steps (32); square root retires two operand bits a cycle (WIDTH/2
// steps); the ceiling log scans for the leading one of a-1, up to WIDTH steps.
// The output register holds a finished result while the next request is
// accepted.
module integer_calculator_alu_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // command [2:0], operand_a [34:3], operand_b [66:35], zero pad [71:67]
   input  logic [icalc_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // result_value [63:0], status [65:64], zero pad [71:66]
   output logic [icalc_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import icalc_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [1:0]        eop_ff, eop_in;
   logic              neg_ff, neg_in;
   logic              rem_sel_ff, rem_sel_in;
   logic [RES_W-1:0]  pend_val_ff, pend_val_in;
   logic [STS_W-1:0]  pend_sts_ff, pend_sts_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RES_W-1:0]  rsp_val_ff, rsp_val_in;
   logic [STS_W-1:0]  rsp_sts_ff, rsp_sts_in;

   logic [CMD_W-1:0]        cmd;
   logic signed [WIDTH-1:0] a_w, b_w;
   logic                    a_neg, b_neg;
   logic [WIDTH-1:0]        a_mag, b_mag;
   logic                    accept, out_free;
   logic                    use_eng;
   logic [RES_W-1:0]        imm_val, fin_val, prod_ext;
   logic [STS_W-1:0]        imm_sts;
   eng_req_type             eng_req;
   eng_rsp_type             eng_rsp;

   // Unpack the request and take operand magnitudes
   assign cmd    = req_tdata[CMD_W-1:0];
   assign a_w    = req_tdata[CMD_W +: WIDTH];
   assign b_w    = req_tdata[CMD_W+FIELD_W +: WIDTH];
   assign a_neg  = a_w[WIDTH-1];
   assign b_neg  = b_w[WIDTH-1];
   assign a_mag  = a_neg ? (WIDTH'(0) - a_w) : a_w;
   assign b_mag  = b_neg ? (WIDTH'(0) - b_w) : b_w;
   assign accept = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);

   // Decode the command: immediate result or a serial unit job
   always_comb begin
      use_eng     = 1'b0;
      imm_val     = '0;
      imm_sts     = STS_OK;
      eng_req.op  = ENG_MUL;
      eng_req.a   = a_mag;
      eng_req.b   = b_mag;
      unique case (cmd)
         CMD_ADD: imm_val = RES_W'(a_w) + RES_W'(b_w);
         CMD_SUB: imm_val = RES_W'(a_w) - RES_W'(b_w);
         CMD_MUL: use_eng = 1'b1;
         CMD_DIV, CMD_MOD: begin
            priority if (b_w == 0) begin
               imm_sts = STS_DIV_ZERO;
            end else if (a_neg || b_neg) begin
               imm_sts = STS_INVALID;
            end else begin
               use_eng    = 1'b1;
               eng_req.op = ENG_DIV;
            end
         end
         CMD_SQUARE: begin
            use_eng   = 1'b1;
            eng_req.b = a_mag;
         end
         CMD_SQRT: begin
            if (a_neg) begin
               imm_sts = STS_INVALID;
            end else begin
               use_eng    = 1'b1;
               eng_req.op = ENG_SQRT;
            end
         end
         default: begin
            priority if (a_w == 0) begin
               imm_sts = STS_INVALID;
            end else if (a_neg || a_w == 1) begin
               imm_val = '0;
            end else begin
               use_eng    = 1'b1;
               eng_req.op = ENG_LOG;
               eng_req.a  = a_mag - WIDTH'(1);
            end
         end
      endcase
      eng_req.start = accept && use_eng;
   end

   icalc_serial_unit u_serial (
      .clock   (clock),
      .reset   (reset),
      .eng_req (eng_req),
      .eng_rsp (eng_rsp)
   );

   // Form the final value from the serial unit result
   assign prod_ext = RES_W'({eng_rsp.hi, eng_rsp.lo});
   always_comb begin
      unique case (eop_ff)
         ENG_MUL: fin_val = neg_ff ? (RES_W'(0) - prod_ext) : prod_ext;
         ENG_DIV: fin_val = rem_sel_ff ? RES_W'(eng_rsp.hi) : RES_W'(eng_rsp.lo);
         default: fin_val = RES_W'(eng_rsp.lo);
      endcase
   end

   // Sequence: accept, run on the serial unit if needed, hold for the output register
   always_comb begin
      state_in     = state_ff;
      eop_in       = eop_ff;
      neg_in       = neg_ff;
      rem_sel_in   = rem_sel_ff;
      pend_val_in  = pend_val_ff;
      pend_sts_in  = pend_sts_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_val_in   = rsp_val_ff;
      rsp_sts_in   = rsp_sts_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               eop_in     = eng_req.op;
               neg_in     = (cmd == CMD_MUL) && (a_neg ^ b_neg);
               rem_sel_in = (cmd == CMD_MOD);
               if (use_eng) begin
                  state_in = ST_RUN;
               end else begin
                  pend_val_in = imm_val;
                  pend_sts_in = imm_sts;
                  state_in    = ST_HOLD;
               end
            end
         end
         ST_RUN: begin
            if (eng_rsp.done) begin
               pend_val_in = fin_val;
               pend_sts_in = STS_OK;
               state_in    = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_val_in   = pend_val_ff;
               rsp_sts_in   = pend_sts_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      eop_ff      <= eop_in;
      neg_ff      <= neg_in;
      rem_sel_ff  <= rem_sel_in;
      pend_val_ff <= pend_val_in;
      pend_sts_ff <= pend_sts_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_sts_ff  <= rsp_sts_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_sts_ff, rsp_val_ff};

   a_done_in_run: assert property (@(posedge clock) disable iff (reset)
      eng_rsp.done |-> (state_ff == ST_RUN))
      else $error("serial unit finished outside of a run");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_sts_ff != STS_OK) |-> (rsp_val_ff == '0))
      else $error("error response carries a nonzero value");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_sts_ff == STS_OK || rsp_sts_ff == STS_DIV_ZERO ||
                        rsp_sts_ff == STS_INVALID))
      else $error("response status code out of range");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("second request accepted while one is in work");

endmodule

// ----- hw/rtl/icalc_serial_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Integer calculator serial unit
// One bit per cycle shift-add multiply, restoring divide, two bits per cycle
// restoring square root and a leading-one scan for the ceiling log.
// ---------------------------------------------------------------------------
module icalc_serial_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  icalc_pkg::eng_req_type eng_req,
   output icalc_pkg::eng_rsp_type eng_rsp
);
   import icalc_pkg::*;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [1:0]       op_ff, op_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0] hi_ff, hi_in;
   logic [WIDTH-1:0] lo_ff, lo_in;
   logic [WIDTH-1:0] mb_ff, mb_in;

   logic             last;
   logic [WIDTH:0]   sum;
   logic [WIDTH:0]   trial;
   logic [WIDTH-1:0] rem_sh;
   logic [1:0]       pair;

   // Advance one step of the selected operation
   always_comb begin
      busy_in = busy_ff;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      mb_in   = mb_ff;
      last    = 1'b0;
      sum     = '0;
      trial   = '0;
      rem_sh  = '0;
      pair    = lo_ff[2*SQ_STEPS-1 -: 2];
      if (busy_ff) begin
         last   = (cnt_ff == CNT_W'(1));
         cnt_in = cnt_ff - CNT_W'(1);
         unique case (op_ff)
            ENG_MUL: begin
               sum   = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mb_ff} : '0);
               hi_in = sum[WIDTH:1];
               lo_in = {sum[0], lo_ff[WIDTH-1:1]};
            end
            ENG_DIV: begin
               rem_sh = {hi_ff[WIDTH-2:0], lo_ff[WIDTH-1]};
               trial  = {1'b0, rem_sh} - {1'b0, mb_ff};
               if (!trial[WIDTH]) begin
                  hi_in = trial[WIDTH-1:0];
                  lo_in = {lo_ff[WIDTH-2:0], 1'b1};
               end else begin
                  hi_in = rem_sh;
                  lo_in = {lo_ff[WIDTH-2:0], 1'b0};
               end
            end
            ENG_SQRT: begin
               rem_sh = {hi_ff[WIDTH-3:0], pair};
               trial  = {1'b0, rem_sh} - {1'b0, mb_ff[WIDTH-3:0], 2'b01};
               lo_in  = {lo_ff[WIDTH-3:0], 2'b00};
               if (!trial[WIDTH]) begin
                  hi_in = trial[WIDTH-1:0];
                  mb_in = {mb_ff[WIDTH-2:0], 1'b1};
               end else begin
                  hi_in = rem_sh;
                  mb_in = {mb_ff[WIDTH-2:0], 1'b0};
               end
            end
            default: begin
               // Leading-one scan: the bit length of a-1 is the ceiling log
               if (lo_ff[WIDTH-1]) begin
                  last   = 1'b1;
                  cnt_in = cnt_ff;
                  lo_in  = WIDTH'(cnt_ff);
               end else begin
                  last  = 1'b0;
                  lo_in = {lo_ff[WIDTH-2:0], 1'b0};
               end
            end
         endcase
         busy_in = !last;
      end
      done_in = busy_ff && last;

      // Load a new request
      if (eng_req.start) begin
         busy_in = 1'b1;
         op_in   = eng_req.op;
         hi_in   = '0;
         lo_in   = eng_req.a;
         mb_in   = (eng_req.op == ENG_SQRT) ? '0 : eng_req.b;
         cnt_in  = (eng_req.op == ENG_SQRT) ? CNT_W'(SQ_STEPS) : CNT_W'(WIDTH);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      mb_ff  <= mb_in;
   end

   assign eng_rsp.done = done_ff;
   assign eng_rsp.hi   = hi_ff;
   assign eng_rsp.lo   = (op_ff == ENG_SQRT) ? mb_ff : lo_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      eng_req.start |-> !busy_ff)
      else $error("serial unit started while busy");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("serial unit done while still busy");

   a_cnt_live: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff != '0))
      else $error("serial unit step count ran out");

endmodule
